@@ rtl/rbr_pkg.sv @@
// Shared types and constants of the retransmit byte ring.
package rbr_pkg;

  localparam int DEPTH = 4096;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Fixed field widths of the request and response ports.
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int TIME_W = 32;
  localparam int AMT_W  = 13;
  localparam int SEQ_W  = 32;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (AMT_W > CNT_W) ? AMT_W : CNT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_RETIME = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_POP_BIG  = 2'd2,
    ST_PEEK_OUT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic finish;
  } rbr_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  retime_none;
    logic  walk_last;
    logic  out_busy;
  } rbr_sts_t;

endpackage

@@ rtl/rbr_ctrl.sv @@
// Sequencing state machine of the retransmit byte ring.
module rbr_ctrl import rbr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  rbr_sts_t sts,
  output rbr_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.kind == KIND_RETIME && !sts.retime_none) state_next = S_WALK;
        else state_next = S_FINISH;
      end
      S_WALK: begin
        if (sts.walk_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC:   cmd.exec = 1'b1;
      S_WALK:   cmd.walk = 1'b1;
      S_FINISH: cmd.finish = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

@@ rtl/rbr_dp.sv @@
// Ring storage, pointers and response register of the retransmit byte ring.
module rbr_dp import rbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rbr_cmd_t          cmd,
  output rbr_sts_t          sts,
  input  logic [KIND_W-1:0] kind,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [TIME_W-1:0] time_in,
  input  logic [AMT_W-1:0]  amount,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] byte_out,
  output logic [TIME_W-1:0] time_out,
  output logic [STAT_W-1:0] status,
  output logic [AMT_W-1:0]  fill_count,
  output logic [SEQ_W-1:0]  front_seq,
  output logic [AMT_W-1:0]  done_count
);

  // Latched request
  kind_t             kind_q;
  logic [BYTE_W-1:0] byte_q;
  logic [TIME_W-1:0] time_q;
  logic [AMT_W-1:0]  amount_q;

  // Ring state
  logic [AW-1:0]     head;
  logic [CNT_W-1:0]  held;
  logic [SEQ_W-1:0]  seq;

  // Per-request working registers
  status_t           res_status;
  logic [CNT_W-1:0]  done_q;
  logic              peek_ok;
  logic [AW-1:0]     walk;
  logic [BYTE_W-1:0] rd_byte;
  logic [TIME_W-1:0] rd_time;

  logic [BYTE_W-1:0] byte_mem [DEPTH];
  logic [TIME_W-1:0] time_mem [DEPTH];

  logic [CMP_W-1:0]  amt_ext, held_ext;
  logic [CNT_W-1:0]  offset;
  logic [SUM_W-1:0]  sum;
  logic [AW-1:0]     slot;
  logic              full;
  logic              push_ok;

  assign amt_ext  = CMP_W'(amount_q);
  assign held_ext = CMP_W'(held);
  assign full     = (held == CNT_W'(DEPTH));
  assign push_ok  = cmd.exec && kind_q == KIND_PUSH && !full;

  // Slot of an offset from the head, wrapped once
  always_comb begin
    if (cmd.walk) offset = CNT_W'(walk);
    else if (kind_q == KIND_PUSH) offset = held;
    else offset = CNT_W'(amount_q);
    sum  = SUM_W'(head) + SUM_W'(offset);
    slot = (sum >= SUM_W'(DEPTH)) ? AW'(sum - SUM_W'(DEPTH)) : AW'(sum);
  end

  assign sts.kind        = kind_q;
  assign sts.retime_none = (amount_q == '0) || (held == '0);
  assign sts.walk_last   = (CNT_W'(walk) + CNT_W'(1)) == done_q;
  assign sts.out_busy    = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q   <= kind_t'(kind);
      byte_q   <= byte_in;
      time_q   <= time_in;
      amount_q <= amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      held <= '0;
      seq  <= '0;
    end else if (cmd.exec) begin
      if (kind_q == KIND_PUSH && !full) begin
        held <= held + CNT_W'(1);
      end else if (kind_q == KIND_POP && amt_ext <= held_ext) begin
        head <= slot;
        seq  <= seq + SEQ_W'(amount_q);
        held <= held - CNT_W'(amount_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      walk    <= '0;
      peek_ok <= 1'b0;
      done_q  <= '0;
      unique case (kind_q)
        KIND_PUSH:   res_status <= full ? ST_FULL : ST_OK;
        KIND_POP:    res_status <= (amt_ext > held_ext) ? ST_POP_BIG : ST_OK;
        KIND_PEEK: begin
          res_status <= (amt_ext >= held_ext) ? ST_PEEK_OUT : ST_OK;
          peek_ok    <= (amt_ext < held_ext);
        end
        KIND_RETIME: begin
          res_status <= ST_OK;
          done_q     <= (amt_ext < held_ext) ? CNT_W'(amount_q) : held;
        end
        default: res_status <= ST_OK;
      endcase
    end else if (cmd.walk) begin
      walk <= walk + AW'(1);
    end
  end

  // Storage: write on push and retime walk, registered read on peek
  always_ff @(posedge clk) begin
    if (push_ok) begin
      byte_mem[slot] <= byte_q;
      time_mem[slot] <= time_q;
    end else if (cmd.walk) begin
      time_mem[slot] <= time_q;
    end
    if (cmd.exec && kind_q == KIND_PEEK) begin
      rd_byte <= byte_mem[slot];
      rd_time <= time_mem[slot];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      byte_out   <= peek_ok ? rd_byte : '0;
      time_out   <= peek_ok ? rd_time : '0;
      status     <= res_status;
      fill_count <= AMT_W'(held);
      front_seq  <= seq;
      done_count <= AMT_W'(done_q);
    end
  end

endmodule

@@ rtl/retransmit_byte_ring_core.sv @@
// Top level of the retransmit byte ring: controller plus datapath.
//
//  Channel   Direction  Handshake           Payload
//  request   in         in_valid/in_stall   kind, byte_in, time_in, amount
//  response  out        out_valid/out_stall byte_out, time_out, status,
//                                           fill_count, front_seq, done_count
//
// Push, pop and peek step through accept, execute, then load the response
// register. Retime adds a walk over min(amount, fill) entries before the load,
// since the single write port of the time store is stepped one entry per cycle.
// Reset (rst, synchronous) clears head, fill, sequence, controller state and
// out_valid; the stores hold no reset value and need no clearing pass.
// A new request is accepted while an earlier response still waits; when the
// response register is still held by out_stall, the request stalls in its
// final step until the register frees.
module retransmit_byte_ring_core import rbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [TIME_W-1:0] time_in,
  input  logic [AMT_W-1:0]  amount,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] byte_out,
  output logic [TIME_W-1:0] time_out,
  output logic [STAT_W-1:0] status,
  output logic [AMT_W-1:0]  fill_count,
  output logic [SEQ_W-1:0]  front_seq,
  output logic [AMT_W-1:0]  done_count
);

  rbr_cmd_t cmd;
  rbr_sts_t sts;

  // Sequence each request through execute, retime walk and response load
  rbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold ring state, stores and the response register
  rbr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .byte_in    (byte_in),
    .time_in    (time_in),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_out   (byte_out),
    .time_out   (time_out),
    .status     (status),
    .fill_count (fill_count),
    .front_seq  (front_seq),
    .done_count (done_count)
  );

endmodule
